// ===== rtl/framed_byte_ring_queue_unit_defines.svh =====
// assertion macros of the framed byte ring queue rtl
// no dependencies; included by fbrq_back, which carries concurrent checks
`ifndef FRAMED_BYTE_RING_QUEUE_UNIT_DEFINES_SVH
`define FRAMED_BYTE_RING_QUEUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FBRQ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fbrq check failed");
`define FBRQ_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("fbrq forbidden condition");
`else
`define FBRQ_ASSERT(name, clk, rst, prop)
`define FBRQ_NEVER(name, clk, rst, expr)
`endif
`endif

// ===== rtl/fbrq_pkg.sv =====
// types and constants of the framed byte ring queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fbrq_pkg;
   localparam int unsigned HDR_BYTES      = 16;
   localparam int unsigned END_BYTES      = 4;
   localparam int unsigned FRAME_OVERHEAD = HDR_BYTES + END_BYTES;

   typedef enum logic [1:0] {
      REQ_PUSH_BEGIN = 2'd0,
      REQ_PUSH_BYTE  = 2'd1,
      REQ_POP_START  = 2'd2,
      REQ_POP_READ   = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_BAD     = 3'd3,
      ST_CORRUPT = 3'd4,
      ST_TOOLONG = 3'd5,
      ST_SEQ     = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_READ,
      S_HDR_CHK,
      S_END_CHK,
      S_BYTE_CHK,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_HDR,
      PH_END,
      PH_BYTE
   } phase_type;

   typedef enum logic [0:0] {
      CSR_BEGIN_SENTINEL = 1'b0,
      CSR_END_SENTINEL   = 1'b1
   } csr_index_type;

   typedef struct packed {
      req_kind_type kind;
      logic [7:0]   data;
      logic [11:0]  len;
      logic [63:0]  stamp;
      logic [12:0]  limit;
   } req_item_type;

   typedef struct packed {
      logic [31:0] begin_word;
      logic [31:0] end_word;
   } cfg_type;
endpackage
`default_nettype wire

// ===== rtl/fbrq_if.sv =====
// request and response channel interfaces of the framed byte ring queue
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface fbrq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  payload_byte;
   logic [11:0] payload_length;
   logic [63:0] stamp_in;
   logic [12:0] buffer_limit;
   modport source (output valid, req_type, payload_byte, payload_length, stamp_in,
                   buffer_limit, input ready);
   modport sink   (input valid, req_type, payload_byte, payload_length, stamp_in,
                   buffer_limit, output ready);
endinterface

interface fbrq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  byte_out;
   logic        last_byte;
   logic [11:0] length_out;
   logic [63:0] stamp_out;
   modport source (output valid, status, byte_out, last_byte, length_out, stamp_out,
                   input ready);
   modport sink   (input valid, status, byte_out, last_byte, length_out, stamp_out,
                   output ready);
endinterface
`default_nettype wire

// ===== rtl/fbrq_front.sv =====
// request intake: decodes requests and holds them in a two-entry queue
// depends on fbrq_pkg and fbrq_if
`timescale 1ns / 1ps
`default_nettype none
module fbrq_front (
   input  wire                  clock,
   input  wire                  reset,
   fbrq_req_if.sink             req_if,
   output fbrq_pkg::req_item_type q_item,
   output logic                 q_valid,
   input  wire                  q_take
);
   import fbrq_pkg::*;

   req_item_type fifo_ff [2];
   logic         wp_ff, wp_in;
   logic         rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;
   req_item_type item_dec;

   // classify the incoming transfer
   always_comb begin
      item_dec.kind  = req_kind_type'(req_if.req_type);
      item_dec.data  = req_if.payload_byte;
      item_dec.len   = req_if.payload_length;
      item_dec.stamp = req_if.stamp_in;
      item_dec.limit = req_if.buffer_limit;
   end

   assign req_if.ready = (cnt_ff != 2'd2);
   assign push         = req_if.valid && req_if.ready;
   assign q_valid      = (cnt_ff != 2'd0);
   assign pop          = q_take && q_valid;
   assign q_item       = fifo_ff[rp_ff];

   // queue pointers
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= item_dec;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/fbrq_back.sv =====
// ring sequencer: byte ring memory, pointers, header and sentinel handling
// depends on fbrq_pkg, fbrq_if and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "framed_byte_ring_queue_unit_defines.svh"
module fbrq_back #(
   parameter int unsigned RING_BYTES = 4096
) (
   input  wire                    clock,
   input  wire                    reset,
   input  fbrq_pkg::cfg_type      cfg,
   input  fbrq_pkg::req_item_type q_item,
   input  wire                    q_valid,
   output logic                   q_take,
   fbrq_rsp_if.source             rsp_if
);
   import fbrq_pkg::*;

   localparam int unsigned AW = $clog2(RING_BYTES);
   localparam int unsigned CW = AW + 1;

   // ring memory
   logic [7:0]    mem [RING_BYTES];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    mem_wdata;
   logic [AW-1:0] mem_raddr;
   logic [7:0]    rd_data_ff;

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   req_item_type  item_ff, item_in;
   logic [AW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0] wcur_ff, wcur_in, rcur_ff, rcur_in, wk_ff, wk_in;
   logic [CW-1:0] wrem_ff, wrem_in, rrem_ff, rrem_in;
   logic          pushop_ff, pushop_in, popop_ff, popop_in;
   logic [4:0]    left_ff, left_in;
   logic          pend_ff, pend_in;
   logic          last_ff, last_in;
   logic [127:0]  sh_ff, sh_in;
   logic [159:0]  wd_ff, wd_in;
   status_type    st_ff, st_in;
   logic [7:0]    rb_ff, rb_in;
   logic          rl_ff, rl_in;
   logic [11:0]   rlen_ff, rlen_in;
   logic [63:0]   rstamp_ff, rstamp_in;
   logic          ov_ff, ov_in;
   logic [2:0]    os_ff, os_in;
   logic [7:0]    ob_ff, ob_in;
   logic          ol_ff, ol_in;
   logic [11:0]   olen_ff, olen_in;
   logic [63:0]   ostamp_ff, ostamp_in;

   function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
      inc = (a == AW'(RING_BYTES - 1)) ? '0 : a + AW'(1);
   endfunction

   // sequencer next state
   always_comb begin
      logic [12:0]   total13;
      logic [CW-1:0] room;
      logic [CW-1:0] used;
      logic [31:0]   total32;
      logic [31:0]   len32;
      state_in  = state_ff;
      phase_in  = phase_ff;
      item_in   = item_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      wcur_in   = wcur_ff;
      rcur_in   = rcur_ff;
      wk_in     = wk_ff;
      wrem_in   = wrem_ff;
      rrem_in   = rrem_ff;
      pushop_in = pushop_ff;
      popop_in  = popop_ff;
      left_in   = left_ff;
      pend_in   = 1'b0;
      last_in   = last_ff;
      sh_in     = sh_ff;
      wd_in     = wd_ff;
      st_in     = st_ff;
      rb_in     = rb_ff;
      rl_in     = rl_ff;
      rlen_in   = rlen_ff;
      rstamp_in = rstamp_ff;
      q_take    = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = wk_ff;
      mem_wdata = wd_ff[7:0];
      mem_raddr = wk_ff;
      total13   = 13'(FRAME_OVERHEAD) + {1'b0, q_item.len};
      room      = (head_ff <= tail_ff)
                  ? CW'(RING_BYTES) - {1'b0, tail_ff} + {1'b0, head_ff}
                  : {1'b0, head_ff} - {1'b0, tail_ff};
      used      = (head_ff < tail_ff)
                  ? {1'b0, tail_ff} - {1'b0, head_ff}
                  : CW'(RING_BYTES) + {1'b0, tail_ff} - {1'b0, head_ff};
      total32   = sh_ff[127:96];
      len32     = total32 - 32'(FRAME_OVERHEAD);
      if (pend_ff) begin
         sh_in = {rd_data_ff, sh_ff[127:8]};
      end
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_take    = 1'b1;
               item_in   = q_item;
               st_in     = ST_OK;
               rb_in     = '0;
               rl_in     = 1'b0;
               rlen_in   = '0;
               rstamp_in = '0;
               state_in  = S_RESP;
               case (q_item.kind)
                  REQ_PUSH_BEGIN: begin
                     pushop_in = 1'b0;
                     if (32'(total13) >= 32'(room)) begin
                        st_in = ST_FULL;
                     end else begin
                        wd_in     = {cfg.end_word, 19'd0, total13, q_item.stamp,
                                     cfg.begin_word};
                        wk_in     = tail_ff;
                        left_in   = (q_item.len == '0) ? 5'd20 : 5'd16;
                        last_in   = (q_item.len == '0);
                        wrem_in   = CW'(q_item.len);
                        pushop_in = (q_item.len != '0);
                        state_in  = S_WRITE;
                     end
                  end
                  REQ_PUSH_BYTE: begin
                     if (!pushop_ff) begin
                        st_in = ST_SEQ;
                     end else begin
                        last_in  = (wrem_ff == CW'(1));
                        wd_in    = {120'd0, cfg.end_word, q_item.data};
                        left_in  = (wrem_ff == CW'(1)) ? 5'd5 : 5'd1;
                        wrem_in  = wrem_ff - CW'(1);
                        wk_in    = wcur_ff;
                        if (wrem_ff == CW'(1)) begin
                           pushop_in = 1'b0;
                        end
                        state_in = S_WRITE;
                     end
                  end
                  REQ_POP_START: begin
                     popop_in = 1'b0;
                     if (head_ff == tail_ff) begin
                        st_in = ST_EMPTY;
                     end else begin
                        wk_in    = head_ff;
                        left_in  = 5'd16;
                        phase_in = PH_HDR;
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     if (!popop_ff) begin
                        st_in = ST_SEQ;
                     end else begin
                        last_in  = (rrem_ff == CW'(1));
                        left_in  = (rrem_ff == CW'(1)) ? 5'd5 : 5'd1;
                        rrem_in  = rrem_ff - CW'(1);
                        wk_in    = rcur_ff;
                        phase_in = PH_BYTE;
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end
         // one byte written per cycle from the low end of the shift word
         S_WRITE: begin
            mem_we  = 1'b1;
            wd_in   = {8'd0, wd_ff[159:8]};
            wk_in   = inc(wk_ff);
            left_in = left_ff - 5'd1;
            if (left_ff == 5'd1) begin
               if (last_ff) begin
                  tail_in = inc(wk_ff);
               end else begin
                  wcur_in = inc(wk_ff);
               end
               state_in = S_RESP;
            end
         end
         // one read issued per cycle, data shifted in on the next cycle
         S_READ: begin
            if (left_ff != 5'd0) begin
               wk_in   = inc(wk_ff);
               left_in = left_ff - 5'd1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               case (phase_ff)
                  PH_HDR:  state_in = S_HDR_CHK;
                  PH_END:  state_in = S_END_CHK;
                  default: state_in = S_BYTE_CHK;
               endcase
            end
         end
         S_HDR_CHK: begin
            rstamp_in = sh_ff[95:32];
            state_in  = S_RESP;
            if (sh_ff[31:0] != cfg.begin_word) begin
               st_in = ST_BAD;
            end else if (total32 < 32'(FRAME_OVERHEAD) || total32 > 32'(used)) begin
               st_in = ST_CORRUPT;
            end else begin
               rlen_in = len32[11:0];
               if (len32 + 32'(END_BYTES) > 32'(item_ff.limit)) begin
                  st_in = ST_TOOLONG;
               end else begin
                  rcur_in = wk_ff;
                  rrem_in = len32[CW-1:0];
                  if (len32 == 32'd0) begin
                     left_in  = 5'd4;
                     phase_in = PH_END;
                     state_in = S_READ;
                  end else begin
                     popop_in = 1'b1;
                  end
               end
            end
         end
         S_END_CHK: begin
            if (sh_ff[127:96] != cfg.end_word) begin
               st_in = ST_BAD;
            end else begin
               head_in = wk_ff;
            end
            state_in = S_RESP;
         end
         S_BYTE_CHK: begin
            if (last_ff) begin
               rb_in    = sh_ff[95:88];
               rl_in    = 1'b1;
               popop_in = 1'b0;
               if (sh_ff[127:96] != cfg.end_word) begin
                  st_in = ST_BAD;
               end else begin
                  head_in = wk_ff;
               end
            end else begin
               rb_in   = sh_ff[127:120];
               rcur_in = wk_ff;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!ov_ff || rsp_if.ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register, refilled when empty or taken
   always_comb begin
      ov_in     = ov_ff && !rsp_if.ready;
      os_in     = os_ff;
      ob_in     = ob_ff;
      ol_in     = ol_ff;
      olen_in   = olen_ff;
      ostamp_in = ostamp_ff;
      if (state_ff == S_RESP && (!ov_ff || rsp_if.ready)) begin
         ov_in     = 1'b1;
         os_in     = st_ff;
         ob_in     = rb_ff;
         ol_in     = rl_ff;
         olen_in   = (st_ff == ST_OK || st_ff == ST_TOOLONG) ? rlen_ff : '0;
         ostamp_in = rstamp_ff;
      end
   end

   assign rsp_if.valid      = ov_ff;
   assign rsp_if.status     = os_ff;
   assign rsp_if.byte_out   = ob_ff;
   assign rsp_if.last_byte  = ol_ff;
   assign rsp_if.length_out = olen_ff;
   assign rsp_if.stamp_out  = ostamp_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         wcur_ff   <= '0;
         rcur_ff   <= '0;
         wrem_ff   <= '0;
         rrem_ff   <= '0;
         pushop_ff <= 1'b0;
         popop_ff  <= 1'b0;
         pend_ff   <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         wcur_ff   <= wcur_in;
         rcur_ff   <= rcur_in;
         wrem_ff   <= wrem_in;
         rrem_ff   <= rrem_in;
         pushop_ff <= pushop_in;
         popop_ff  <= popop_in;
         pend_ff   <= pend_in;
         ov_ff     <= ov_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      phase_ff  <= phase_in;
      item_ff   <= item_in;
      wk_ff     <= wk_in;
      left_ff   <= left_in;
      last_ff   <= last_in;
      sh_ff     <= sh_in;
      wd_ff     <= wd_in;
      st_ff     <= st_in;
      rb_ff     <= rb_in;
      rl_ff     <= rl_in;
      rlen_ff   <= rlen_in;
      rstamp_ff <= rstamp_in;
      os_ff     <= os_in;
      ob_ff     <= ob_in;
      ol_ff     <= ol_in;
      olen_ff   <= olen_in;
      ostamp_ff <= ostamp_in;
   end

   // ring memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   `FBRQ_ASSERT(a_pend_after_read, clock, reset, pend_ff |-> $past(state_ff) == S_READ)
   `FBRQ_NEVER(a_write_no_count, clock, reset, state_ff == S_WRITE && left_ff == 5'd0)
   `FBRQ_ASSERT(a_tail_on_write, clock, reset, (tail_ff != $past(tail_ff)) |-> $past(state_ff) == S_WRITE)
   `FBRQ_NEVER(a_take_busy, clock, reset, q_take && state_ff != S_IDLE)
endmodule
`default_nettype wire

// ===== rtl/framed_byte_ring_queue_unit.sv =====
// top level of the framed byte ring queue: sentinel registers, intake, sequencer
// depends on fbrq_pkg, fbrq_if, fbrq_front and fbrq_back
//
// channel   dir  transfer when         carries
// req_if    in   valid & ready         request kind, byte, length, stamp, limit
// rsp_if    out  valid & ready         status, byte, last flag, length, stamp
// csr_*     in   csr_we                sentinel register index and value
//
// begin push writes the header, and also the end sentinel with an empty payload,
// bound by one ring write per cycle; a payload byte also writes the end sentinel when final
// start pop reads the header, and also the end sentinel for an empty payload; read byte
// also reads the end sentinel when final; both bound by the single registered ring read port
// the two-entry request queue takes transfers while it has room, also while the sequencer
// works or a result waits; reset clears pointers and flags, the ring is not cleared
`timescale 1ns / 1ps
`default_nettype none
module framed_byte_ring_queue_unit #(
   parameter int unsigned RING_BYTES = 4096
) (
   input  wire        clock,
   input  wire        reset,
   fbrq_req_if.sink   req_if,
   fbrq_rsp_if.source rsp_if,
   input  wire        csr_we,
   input  wire        csr_index,
   input  wire [31:0] csr_wdata
);
   import fbrq_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   req_item_type q_item;
   logic         q_valid;
   logic         q_take;

   // sentinel registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_BEGIN_SENTINEL: cfg_in.begin_word = csr_wdata;
            default:            cfg_in.end_word   = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_word <= 32'd1313292894;
         cfg_ff.end_word   <= 32'd608456253;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   fbrq_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_take  (q_take)
   );

   fbrq_back #(
      .RING_BYTES (RING_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_item  (q_item),
      .q_valid (q_valid),
      .q_take  (q_take),
      .rsp_if  (rsp_if)
   );
endmodule
`default_nettype wire

// ===== tb/tb_framed_byte_ring_queue_unit.sv =====
// self-checking testbench of the framed byte ring queue unit
// depends on fbrq_pkg, fbrq_if and framed_byte_ring_queue_unit; holds its own ring model
`timescale 1ns / 1ps
module tb_framed_byte_ring_queue_unit;
   import fbrq_pkg::*;

   localparam int unsigned RING        = 4096;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned DRAIN_GAP   = 40;

   typedef struct {
      status_type  status;
      logic [7:0]  byte_val;
      logic        last;
      logic [11:0] len;
      logic [63:0] stamp;
   } ring_rsp_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   csr_index_type csr_index;
   logic [31:0] csr_wdata;

   fbrq_req_if req_ch ();
   fbrq_rsp_if rsp_ch ();

   framed_byte_ring_queue_unit #(.RING_BYTES(RING)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // ring model state
   logic [7:0]  ring_mem [RING];
   int unsigned m_head, m_tail, m_wcur, m_wrem, m_rcur, m_rrem;
   bit          m_push_open, m_pop_open;
   logic [31:0] m_begin, m_end;

   ring_rsp_type expected_q[$];
   int unsigned errors;
   int unsigned n_sent;
   int unsigned n_checked;
   int unsigned cycles;
   bit          no_idle;
   bit          run_on;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic int unsigned wrap(int unsigned a);
      return a % RING;
   endfunction

   function automatic void put_le(int unsigned addr, logic [63:0] v, int unsigned n);
      for (int unsigned i = 0; i < n; i++) ring_mem[wrap(addr + i)] = v[8*i +: 8];
   endfunction

   function automatic logic [63:0] get_le(int unsigned addr, int unsigned n);
      logic [63:0] v;
      v = '0;
      for (int unsigned i = 0; i < n; i++) v[8*i +: 8] = ring_mem[wrap(addr + i)];
      return v;
   endfunction

   // expected response of one accepted request; updates the ring model
   function automatic void predict_response(req_kind_type k, logic [7:0] d, logic [11:0] l,
                                            logic [63:0] s, logic [12:0] lim);
      ring_rsp_type r;
      int unsigned total, room, used, plen;
      logic [31:0] sent, tot_word;
      r = '{ST_OK, 8'd0, 1'b0, 12'd0, 64'd0};
      case (k)
         REQ_PUSH_BEGIN: begin
            total = HDR_BYTES + 32'(l) + END_BYTES;
            room = (m_head <= m_tail) ? RING - m_tail + m_head : m_head - m_tail;
            m_push_open = 1'b0;
            if (total >= room) begin
               r.status = ST_FULL;
            end else begin
               put_le(m_tail, 64'(m_begin), 4);
               put_le(m_tail + 4, s, 8);
               put_le(m_tail + 12, 64'(total), 4);
               m_wcur = wrap(m_tail + HDR_BYTES);
               m_wrem = 32'(l);
               if (l == 0) begin
                  put_le(m_wcur, 64'(m_end), END_BYTES);
                  m_tail = wrap(m_wcur + END_BYTES);
               end else begin
                  m_push_open = 1'b1;
               end
            end
         end
         REQ_PUSH_BYTE: begin
            if (!m_push_open) begin
               r.status = ST_SEQ;
            end else begin
               ring_mem[m_wcur] = d;
               m_wcur = wrap(m_wcur + 1);
               m_wrem--;
               if (m_wrem == 0) begin
                  put_le(m_wcur, 64'(m_end), END_BYTES);
                  m_tail = wrap(m_wcur + END_BYTES);
                  m_push_open = 1'b0;
               end
            end
         end
         REQ_POP_START: begin
            m_pop_open = 1'b0;
            if (m_head == m_tail) begin
               r.status = ST_EMPTY;
            end else begin
               used = (m_head < m_tail) ? m_tail - m_head : RING + m_tail - m_head;
               sent = 32'(get_le(m_head, 4));
               tot_word = 32'(get_le(m_head + 12, 4));
               r.stamp = get_le(m_head + 4, 8);
               if (sent != m_begin) begin
                  r.status = ST_BAD;
               end else if (tot_word < HDR_BYTES + END_BYTES || tot_word > used) begin
                  r.status = ST_CORRUPT;
               end else begin
                  plen = tot_word - HDR_BYTES - END_BYTES;
                  r.len = 12'(plen);
                  if (plen + END_BYTES > lim) begin
                     r.status = ST_TOOLONG;
                  end else begin
                     m_rcur = wrap(m_head + HDR_BYTES);
                     m_rrem = plen;
                     if (plen == 0) begin
                        if (get_le(m_rcur, END_BYTES) != m_end) r.status = ST_BAD;
                        else m_head = wrap(m_rcur + END_BYTES);
                     end else begin
                        m_pop_open = 1'b1;
                     end
                  end
               end
            end
         end
         default: begin
            if (!m_pop_open) begin
               r.status = ST_SEQ;
            end else begin
               r.byte_val = ring_mem[m_rcur];
               m_rcur = wrap(m_rcur + 1);
               m_rrem--;
               if (m_rrem == 0) begin
                  r.last = 1'b1;
                  if (get_le(m_rcur, END_BYTES) != m_end) r.status = ST_BAD;
                  else m_head = wrap(m_rcur + END_BYTES);
                  m_pop_open = 1'b0;
               end
            end
         end
      endcase
      expected_q.push_back(r);
   endfunction

   // one request transfer, with random idle cycles ahead of it unless no_idle is set
   task automatic send_req(req_kind_type k, logic [7:0] d, logic [11:0] l, logic [63:0] s,
                           logic [12:0] lim);
      bit rdy;
      while (!no_idle && $urandom_range(99) < 35) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.req_type       <= k;
      req_ch.payload_byte   <= d;
      req_ch.payload_length <= l;
      req_ch.stamp_in       <= s;
      req_ch.buffer_limit   <= lim;
      do begin
         @(negedge clock);
         rdy = req_ch.ready;
         @(posedge clock);
      end while (!rdy);
      predict_response(k, d, l, s, lim);
      n_sent++;
   endtask

   function automatic logic [63:0] rand_stamp();
      return {$urandom, $urandom};
   endfunction

   task automatic send_rand_fields(req_kind_type k, logic [7:0] d, logic [11:0] l,
                                   logic [12:0] lim);
      send_req(k, d, l, rand_stamp(), lim);
   endtask

   // lower valid and wait until every response has come back
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   // one register write; the caller lowers the write enable afterwards
   task automatic write_csr(csr_index_type idx, logic [31:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      if (idx == CSR_BEGIN_SENTINEL) m_begin = v;
      else m_end = v;
   endtask

   task automatic set_sentinels(logic [31:0] b, logic [31:0] e);
      wait_quiet();
      write_csr(CSR_BEGIN_SENTINEL, b);
      write_csr(CSR_END_SENTINEL, e);
      csr_we <= 1'b0;
   endtask

   task automatic push_message(int unsigned len, int unsigned keep);
      send_rand_fields(REQ_PUSH_BEGIN, 8'($urandom), 12'(len), 13'($urandom_range(8191)));
      for (int unsigned i = 0; i < len && i < keep; i++)
         send_rand_fields(REQ_PUSH_BYTE, 8'($urandom), 12'($urandom),
                          13'($urandom_range(8191)));
   endtask

   task automatic pop_message(logic [12:0] lim, int unsigned keep);
      int unsigned n;
      n = 0;
      send_rand_fields(REQ_POP_START, 8'($urandom), 12'($urandom), lim);
      while (m_pop_open && n < keep) begin
         send_rand_fields(REQ_POP_READ, 8'($urandom), 12'($urandom),
                          13'($urandom_range(8191)));
         n++;
      end
   endtask

   // empties the ring; config must match what the queued messages were written with
   task automatic drain_ring();
      int unsigned guard;
      guard = 0;
      while (m_head != m_tail && guard < 2000) begin
         pop_message(13'd4096, RING);
         guard++;
      end
   endtask

   // response checker
   initial begin
      ring_rsp_type e;
      forever begin
         @(negedge clock);
         if (run_on && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $error("response with nothing expected, status %0d", rsp_ch.status);
               errors++;
            end else begin
               e = expected_q.pop_front();
               n_checked++;
               if (rsp_ch.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.byte_out !== e.byte_val) begin
                  $error("byte_out expected %0h actual %0h", e.byte_val, rsp_ch.byte_out);
                  errors++;
               end
               if (rsp_ch.last_byte !== e.last) begin
                  $error("last_byte expected %0b actual %0b", e.last, rsp_ch.last_byte);
                  errors++;
               end
               if (rsp_ch.length_out !== e.len) begin
                  $error("length_out expected %0d actual %0d", e.len, rsp_ch.length_out);
                  errors++;
               end
               if (rsp_ch.stamp_out !== e.stamp) begin
                  $error("stamp_out expected %0h actual %0h", e.stamp, rsp_ch.stamp_out);
                  errors++;
               end
            end
         end
      end
   end

   // response back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 35);
   end

   // out of sequence requests and an empty pop
   task automatic test_sequence_errors();
      send_req(REQ_POP_READ, 8'hFF, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 13'h1FFF);
      send_req(REQ_PUSH_BYTE, 8'h00, 12'h000, 64'd0, 13'd0);
      send_req(REQ_POP_START, 8'h00, 12'h000, 64'd0, 13'd4096);
   endtask

   // header plus end sentinel only
   task automatic test_empty_payload();
      send_req(REQ_PUSH_BEGIN, 8'h00, 12'd0, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0);
      send_req(REQ_POP_START, 8'h00, 12'd0, 64'd0, 13'd4);
   endtask

   task automatic test_basic_message();
      send_req(REQ_PUSH_BEGIN, 8'h00, 12'd3, 64'h0123_4567_89AB_CDEF, 13'd0);
      send_req(REQ_PUSH_BYTE, 8'h00, 12'd0, 64'd0, 13'd0);
      send_req(REQ_PUSH_BYTE, 8'hFF, 12'd0, 64'd0, 13'd0);
      send_req(REQ_PUSH_BYTE, 8'h5A, 12'd0, 64'd0, 13'd0);
      pop_message(13'd7, RING);
   endtask

   // receiver buffer too small, then just big enough
   task automatic test_too_long();
      push_message(4, 4);
      send_rand_fields(REQ_POP_START, 8'h00, 12'd0, 13'd0);
      send_rand_fields(REQ_POP_START, 8'h00, 12'd0, 13'd7);
      pop_message(13'd8, RING);
   endtask

   // restarted push and restarted pop
   task automatic test_restart();
      push_message(5, 2);
      push_message(1, 1);
      pop_message(13'd4096, 0);
      pop_message(13'd4096, RING);
   endtask

   // message that cannot fit even an empty ring
   task automatic test_full();
      send_rand_fields(REQ_PUSH_BEGIN, 8'h00, 12'd4076, 13'd0);
      send_rand_fields(REQ_PUSH_BYTE, 8'h11, 12'd0, 13'd0);
   endtask

   // begin sentinel changed under a queued message
   task automatic test_bad_begin();
      push_message(1, 1);
      set_sentinels(~m_begin, m_end);
      pop_message(13'd4096, RING);
      set_sentinels(~m_begin, m_end);
      drain_ring();
   endtask

   // end sentinel changed under queued messages, with and without payload
   task automatic test_bad_end();
      push_message(2, 2);
      push_message(0, 0);
      set_sentinels(m_begin, ~m_end);
      pop_message(13'd4096, RING);
      set_sentinels(m_begin, ~m_end);
      pop_message(13'd4096, RING);
      set_sentinels(m_begin, ~m_end);
      send_rand_fields(REQ_POP_START, 8'h00, 12'd0, 13'd4096);
      set_sentinels(m_begin, ~m_end);
      send_rand_fields(REQ_POP_START, 8'h00, 12'd0, 13'd4096);
      drain_ring();
   endtask

   // random traffic under several sentinel settings
   task automatic test_random_traffic();
      logic [31:0] bvals[5];
      logic [31:0] evals[5];
      int unsigned stop, p, len;
      bvals = '{32'd1313292894, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0};
      evals = '{32'd608456253, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0};
      bvals[3] = $urandom; evals[3] = $urandom;
      bvals[4] = $urandom; evals[4] = bvals[4];
      for (int ph = 0; ph < 5; ph++) begin
         drain_ring();
         set_sentinels(bvals[ph], evals[ph]);
         no_idle = (ph == 2);
         if (ph == 0) begin
            // fill with header-only messages until full, empty, then cross the ring end
            for (int unsigned i = 0; i < RING / FRAME_OVERHEAD + 4; i++)
               push_message(0, 0);
            send_rand_fields(REQ_PUSH_BEGIN, 8'h00, 12'd4076, 13'd0);
            drain_ring();
            for (int unsigned i = 0; i < 8; i++)
               push_message(0, 0);
         end
         stop = n_sent + 170;
         while (n_sent < stop) begin
            p = $urandom_range(99);
            if (p < 55) begin
               len = ($urandom_range(49) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(0, 40);
               push_message(len, ($urandom_range(9) == 0) ? $urandom_range(len) : len);
            end else if (p < 90) begin
               pop_message(($urandom_range(99) < 85) ? 13'd4096 : 13'($urandom_range(4096)),
                           ($urandom_range(9) == 0) ? $urandom_range(20) : RING);
            end else begin
               send_req(req_kind_type'($urandom_range(3)), 8'($urandom), 12'($urandom),
                        rand_stamp(), 13'($urandom_range(4096)));
            end
         end
         no_idle = 1'b0;
      end
      drain_ring();
   endtask

   // main sequence
   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_BEGIN_SENTINEL;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.req_type = REQ_PUSH_BEGIN;
      req_ch.payload_byte = '0;
      req_ch.payload_length = '0;
      req_ch.stamp_in = '0;
      req_ch.buffer_limit = '0;
      rsp_ch.ready = 1'b0;
      errors = 0; n_sent = 0; n_checked = 0; cycles = 0;
      no_idle = 1'b0; run_on = 1'b0;
      foreach (ring_mem[i]) ring_mem[i] = 8'h00;
      m_head = 0; m_tail = 0; m_wcur = 0; m_wrem = 0; m_rcur = 0; m_rrem = 0;
      m_push_open = 1'b0; m_pop_open = 1'b0;
      m_begin = 32'd1313292894;
      m_end = 32'd608456253;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_on = 1'b1;
      @(posedge clock);

      test_sequence_errors();
      test_empty_payload();
      test_basic_message();
      test_too_long();
      test_restart();
      test_full();
      test_bad_begin();
      test_bad_end();
      test_random_traffic();

      wait_quiet();
      $display("covered %0d requests and %0d checked responses: framing, wrap, full,",
               n_sent, n_checked);
      $display("empty, sentinel mismatch, buffer limit, restarts and out of sequence");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
